@@ sv/button_click_classifier_unit_assert.svh @@
// Assertion macros shared by the button click classifier RTL.
`ifndef BUTTON_CLICK_CLASSIFIER_UNIT_ASSERT_SVH
`define BUTTON_CLICK_CLASSIFIER_UNIT_ASSERT_SVH

// Checked on every rising clk edge outside reset.
`define BCC_ASSERT(label, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Checked on every rising clk edge, reset included.
`define BCC_ASSERT_ALWAYS(label, prop, msg) \
	label: assert property (@(posedge clk) prop) else $error(msg);

`endif

@@ sv/bcc_pkg.sv @@
// Types, register indexes, reset values and helpers for the button click classifier.
`default_nettype none

package bcc_pkg;

	localparam int unsigned TIME_W  = 32;
	localparam int unsigned CFG_W   = 16;
	localparam int unsigned CFG_IDX_W = 3;

	localparam logic [CFG_IDX_W-1:0] CFG_LONG_MIN      = 3'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_LONG_MAX      = 3'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MIN     = 3'd2;
	localparam logic [CFG_IDX_W-1:0] CFG_SHORT_MAX     = 3'd3;
	localparam logic [CFG_IDX_W-1:0] CFG_NOISE_LIMIT   = 3'd4;
	localparam logic [CFG_IDX_W-1:0] CFG_SELECT_MARGIN = 3'd5;

	localparam logic [CFG_W-1:0] RST_LONG_MIN      = 16'd1100;
	localparam logic [CFG_W-1:0] RST_LONG_MAX      = 16'd2000;
	localparam logic [CFG_W-1:0] RST_SHORT_MIN     = 16'd10;
	localparam logic [CFG_W-1:0] RST_SHORT_MAX     = 16'd200;
	localparam logic [CFG_W-1:0] RST_NOISE_LIMIT   = 16'd2;
	localparam logic [CFG_W-1:0] RST_SELECT_MARGIN = 16'd10;

	typedef enum logic [1:0] {
		CODE_NONE   = 2'd0,
		CODE_LONG   = 2'd1,
		CODE_SELECT = 2'd2,
		CODE_DOUBLE = 2'd3
	} code_t;

	typedef struct packed {
		logic [CFG_W-1:0] long_min;
		logic [CFG_W-1:0] long_max;
		logic [CFG_W-1:0] short_min;
		logic [CFG_W-1:0] short_max;
		logic [CFG_W-1:0] noise_limit;
		logic [CFG_W-1:0] select_margin;
	} cfg_t;

	typedef struct packed {
		logic              for_this_button;
		logic              level;
		logic [TIME_W-1:0] time_ms;
	} item_t;

	typedef struct packed {
		code_t             event_code;
		logic [TIME_W-1:0] interval;
	} result_t;

	// step: classify the staged item; take: receiver pops the result register
	typedef struct packed {
		logic step;
		logic take;
	} ctl_t;

	function automatic logic in_short_window(input logic [TIME_W-1:0] d, input cfg_t cfg);
		return (d >= {{(TIME_W-CFG_W){1'b0}}, cfg.short_min}) &&
			(d <= {{(TIME_W-CFG_W){1'b0}}, cfg.short_max});
	endfunction

endpackage

`default_nettype wire

@@ sv/bcc_in_if.sv @@
// Valid/ready channel carrying button edge items.
`default_nettype none

interface bcc_in_if
	import bcc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic              for_this_button;
	logic              level;
	logic [TIME_W-1:0] time_ms;

	modport source (output valid, output for_this_button, output level, output time_ms,
		input ready);
	modport sink (input valid, input for_this_button, input level, input time_ms,
		output ready);
endinterface

`default_nettype wire

@@ sv/bcc_out_if.sv @@
// Valid/ready channel carrying classification result items.
`default_nettype none

interface bcc_out_if
	import bcc_pkg::*;
();
	logic              valid;
	logic              ready;
	logic [1:0]        event_code;
	logic [TIME_W-1:0] interval;

	modport source (output valid, output event_code, output interval, input ready);
	modport sink (input valid, input event_code, input interval, output ready);
endinterface

`default_nettype wire

@@ sv/bcc_cfg_regs.sv @@
// Configuration register file for the click thresholds.
`default_nettype none

module bcc_cfg_regs
	import bcc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	output cfg_t                      cfg
);

	cfg_t cfg_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.long_min      <= RST_LONG_MIN;
			cfg_q.long_max      <= RST_LONG_MAX;
			cfg_q.short_min     <= RST_SHORT_MIN;
			cfg_q.short_max     <= RST_SHORT_MAX;
			cfg_q.noise_limit   <= RST_NOISE_LIMIT;
			cfg_q.select_margin <= RST_SELECT_MARGIN;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_LONG_MIN:      cfg_q.long_min      <= cfg_wdata;
				CFG_LONG_MAX:      cfg_q.long_max      <= cfg_wdata;
				CFG_SHORT_MIN:     cfg_q.short_min     <= cfg_wdata;
				CFG_SHORT_MAX:     cfg_q.short_max     <= cfg_wdata;
				CFG_NOISE_LIMIT:   cfg_q.noise_limit   <= cfg_wdata;
				CFG_SELECT_MARGIN: cfg_q.select_margin <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

endmodule

`default_nettype wire

@@ sv/bcc_classify.sv @@
// Click phase machine, press/gap classification and result register.
`default_nettype none

module bcc_classify
	import bcc_pkg::*;
(
	input  wire logic    clk,
	input  wire logic    arst_n,
	input  cfg_t         cfg,
	input  ctl_t         ctl,
	input  item_t        item_s1,
	output logic         res_valid_q,
	output result_t      res_q
);

	typedef enum logic [1:0] {
		PH_WAIT_RISE1,
		PH_WAIT_FALL1,
		PH_WAIT_RISE2,
		PH_WAIT_FALL2
	} phase_t;

	phase_t            phase_q, phase_d;
	logic [TIME_W-1:0] rise1_q, fall1_q, rise2_q;
	logic              wr_rise1, wr_fall1, wr_rise2;
	logic [TIME_W-1:0] d_press, d_gap, d_second;
	logic [CFG_W:0]    sel_lo;
	logic [CFG_W-1:0]  sel_hi;
	logic              sel_hi_ok, is_long, is_noise, is_select;
	logic              mine_rise, mine_fall;
	result_t           res_d;

	assign d_press  = item_s1.time_ms - rise1_q;
	assign d_gap    = item_s1.time_ms - fall1_q;
	assign d_second = item_s1.time_ms - rise2_q;

	assign sel_lo    = {1'b0, cfg.short_max} + {1'b0, cfg.select_margin};
	assign sel_hi_ok = cfg.long_min > cfg.select_margin;
	assign sel_hi    = cfg.long_min - cfg.select_margin;

	assign is_long  = (d_press >= {{(TIME_W-CFG_W){1'b0}}, cfg.long_min}) &&
		(d_press <= {{(TIME_W-CFG_W){1'b0}}, cfg.long_max});
	assign is_noise = (d_press != '0) &&
		(d_press <= {{(TIME_W-CFG_W){1'b0}}, cfg.noise_limit});
	assign is_select = sel_hi_ok &&
		(d_press > {{(TIME_W-CFG_W-1){1'b0}}, sel_lo}) &&
		(d_press < {{(TIME_W-CFG_W){1'b0}}, sel_hi});

	assign mine_rise = item_s1.for_this_button && item_s1.level;
	assign mine_fall = item_s1.for_this_button && !item_s1.level;

	always_comb begin
		phase_d        = phase_q;
		wr_rise1       = 1'b0;
		wr_fall1       = 1'b0;
		wr_rise2       = 1'b0;
		res_d.event_code = CODE_NONE;
		res_d.interval = '0;
		case (phase_q)
			PH_WAIT_RISE1: begin
				if (mine_rise) begin
					wr_rise1 = 1'b1;
					phase_d  = PH_WAIT_FALL1;
				end
			end
			PH_WAIT_FALL1: begin
				if (mine_fall) begin
					wr_fall1 = 1'b1;
					if (is_long) begin
						res_d.event_code = CODE_LONG;
						phase_d = PH_WAIT_RISE1;
					end else if (is_noise) begin
						phase_d = PH_WAIT_RISE1;
					end else if (is_select) begin
						res_d.event_code = CODE_SELECT;
						res_d.interval   = d_press;
						phase_d = PH_WAIT_RISE1;
					end else if (in_short_window(d_press, cfg)) begin
						phase_d = PH_WAIT_RISE2;
					end
				end
			end
			PH_WAIT_RISE2: begin
				if (mine_rise) begin
					wr_rise2 = 1'b1;
					phase_d  = in_short_window(d_gap, cfg) ? PH_WAIT_FALL2 : PH_WAIT_RISE1;
				end
			end
			PH_WAIT_FALL2: begin
				if (mine_fall) begin
					if (in_short_window(d_second, cfg))
						res_d.event_code = CODE_DOUBLE;
					phase_d = PH_WAIT_RISE1;
				end
			end
			default: phase_d = PH_WAIT_RISE1;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= PH_WAIT_RISE1;
			rise1_q     <= '0;
			fall1_q     <= '0;
			rise2_q     <= '0;
			res_valid_q <= 1'b0;
			res_q       <= '0;
		end else if (ctl.step) begin
			phase_q     <= phase_d;
			if (wr_rise1)
				rise1_q <= item_s1.time_ms;
			if (wr_fall1)
				fall1_q <= item_s1.time_ms;
			if (wr_rise2)
				rise2_q <= item_s1.time_ms;
			res_valid_q <= 1'b1;
			res_q       <= res_d;
		end else if (ctl.take) begin
			res_valid_q <= 1'b0;
		end
	end

	`include "button_click_classifier_unit_assert.svh"

	`BCC_ASSERT(a_interval_only_select, res_valid_q |-> ((res_q.event_code == CODE_SELECT) == (res_q.interval != '0)), "interval set outside select key")
	`BCC_ASSERT(a_click_ends_sequence, (ctl.step && res_d.event_code != CODE_NONE) |=> (phase_q == PH_WAIT_RISE1), "phase not back to start after a click")
	`BCC_ASSERT(a_foreign_item_ignored, (ctl.step && !item_s1.for_this_button) |=> ($stable(phase_q) && $stable(rise1_q) && $stable(fall1_q)), "foreign item changed state")

endmodule

`default_nettype wire

@@ sv/button_click_classifier_unit.sv @@
// Top level of the button click classifier: input stage, config registers, classifier.
//
// Usage:
//   btn_in carries one button edge item (for_this_button, level, time_ms) per
//   valid/ready handshake; cls_out returns exactly one result item (event_code,
//   interval) for every accepted input item, in order.
//   The cfg_* port writes one of six 16-bit threshold registers per cycle with
//   cfg_we high; write only while no item is in flight.
// Flow: an accepted item is held in the input register and classified into the
//   result register when that register is empty or being taken; cls_out.valid
//   rises with the loaded result, which can then be taken.
// Throughput: one item per cycle while cls_out.ready is high; the
//   subtract-and-compare classification sits between the input register and the
//   result register, so phase state is current for every following item.
// Stall: when cls_out.ready is low the result register holds, the input
//   register fills, and btn_in.ready drops once both are occupied.
// Reset: arst_n low clears both pipeline valids, returns the phase machine to
//   waiting for a first press and loads the default thresholds.
`default_nettype none

module button_click_classifier_unit
	import bcc_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_wdata,
	bcc_in_if.sink                    btn_in,
	bcc_out_if.source                 cls_out
);

	cfg_t    cfg;
	ctl_t    ctl;
	logic    valid_s1;
	item_t   item_s1;
	logic    res_load;
	logic    res_valid_q;
	result_t res_q;

	assign res_load   = !res_valid_q || cls_out.ready;
	assign ctl.step   = valid_s1 && res_load;
	assign ctl.take   = res_valid_q && cls_out.ready;
	assign btn_in.ready = !valid_s1 || res_load;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			valid_s1 <= 1'b0;
		else if (btn_in.ready)
			valid_s1 <= btn_in.valid;
	end

	always_ff @(posedge clk) begin
		if (btn_in.valid && btn_in.ready) begin
			item_s1.for_this_button <= btn_in.for_this_button;
			item_s1.level           <= btn_in.level;
			item_s1.time_ms         <= btn_in.time_ms;
		end
	end

	bcc_cfg_regs u_cfg (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_wdata (cfg_wdata),
		.cfg       (cfg)
	);

	bcc_classify u_classify (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg         (cfg),
		.ctl         (ctl),
		.item_s1     (item_s1),
		.res_valid_q (res_valid_q),
		.res_q       (res_q)
	);

	assign cls_out.valid      = res_valid_q;
	assign cls_out.event_code = res_q.event_code;
	assign cls_out.interval   = res_q.interval;

	`include "button_click_classifier_unit_assert.svh"

	`BCC_ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> (!valid_s1 && !cls_out.valid), "pipeline valid during reset")
	`BCC_ASSERT(a_stalled_stage_holds, (valid_s1 && !res_load) |=> valid_s1, "staged item lost under stall")
	`BCC_ASSERT(a_empty_stage_ready, !valid_s1 |-> btn_in.ready, "input blocked with empty stage")

endmodule

`default_nettype wire
